// ===== hw/rtl/cfa_pkg.sv =====
// Types and constants for the constant folding ALU.
// Holds the transaction structs, the opcode enum and the chain stage record.
package cfa_pkg;

  localparam int unsigned DataW = 64;
  localparam logic [5:0] ShiftLimit = 6'd63;

  typedef enum logic [4:0] {
    CmdAdd   = 5'd0,
    CmdSub   = 5'd1,
    CmdMul   = 5'd2,
    CmdDiv   = 5'd3,
    CmdMod   = 5'd4,
    CmdAnd   = 5'd5,
    CmdOr    = 5'd6,
    CmdXor   = 5'd7,
    CmdShl   = 5'd8,
    CmdShr   = 5'd9,
    CmdEq    = 5'd10,
    CmdNe    = 5'd11,
    CmdLt    = 5'd12,
    CmdLe    = 5'd13,
    CmdGt    = 5'd14,
    CmdGe    = 5'd15,
    CmdOther = 5'd16
  } cfa_cmd_e;

  typedef struct packed {
    logic [4:0]        command;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic              operands_constant;
  } cfa_in_t;

  typedef struct packed {
    logic              folded;
    logic signed [63:0] value;
  } cfa_out_t;

  // One record travelling down the divider chain.
  typedef struct packed {
    logic        valid;
    logic [4:0]  command;
    logic        ok;        // folds, before selection
    logic        neg_q;     // quotient must be negated
    logic        neg_r;     // remainder must be negated
    logic [63:0] misc;      // result of the operations worked out at the entry stage
    logic [63:0] prod_ll;   // low by low partial product
    logic [31:0] prod_x;    // low half of the cross partial products
    logic [63:0] den;       // divisor magnitude
    logic [63:0] rem;       // partial remainder
    logic [63:0] quo;       // dividend bits shifting out, quotient bits in
  } cfa_stage_t;

endpackage

// ===== hw/rtl/cfa_div_cell.sv =====
// One cell of the divider chain: a single restoring division step per cycle while enabled.
// Depends on cfa_pkg for the stage record.
module cfa_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cfa_pkg::cfa_stage_t stage_i,
  output cfa_pkg::cfa_stage_t stage_o
);
  import cfa_pkg::*;

  cfa_stage_t stage_d, stage_q;
  logic [63:0] shifted;
  logic [64:0] diff;

  always_comb begin
    stage_d = stage_i;
    shifted = {stage_i.rem[62:0], stage_i.quo[63]};
    diff    = {1'b0, shifted} - {1'b0, stage_i.den};
    if (!diff[64]) begin
      stage_d.rem = diff[63:0];
      stage_d.quo = {stage_i.quo[62:0], 1'b1};
    end else begin
      stage_d.rem = shifted;
      stage_d.quo = {stage_i.quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== hw/rtl/constant_fold_alu_core.sv =====
// Constant folding ALU: one entry stage, a chain of 64 divider cells and an
// output register. Throughput is one transaction per cycle; the whole chain
// advances together and halts only while the output register holds a
// stalled result. Reset (asynchronous, active low) empties every stage but
// the output value register, which is not reset.
module constant_fold_alu_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cfa_pkg::cfa_in_t  in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cfa_pkg::cfa_out_t out_o
);
  import cfa_pkg::*;

  // The chain moves whenever the output register is free or being emptied.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Entry stage: every operation other than multiply, divide and modulo is
  // worked out here, together with the three partial products of the
  // multiplier and the operand magnitudes that the divider chain works on.
  cfa_stage_t entry_d, entry_q;
  cfa_cmd_e   cmd;
  logic [63:0] a, b, mag_a, mag_b;
  logic       a_neg, b_neg, shift_ok;
  logic [31:0] cross_lo;

  always_comb begin
    cmd      = cfa_cmd_e'(in_i.command);
    a        = in_i.operand_a;
    b        = in_i.operand_b;
    a_neg    = a[63];
    b_neg    = b[63];
    mag_a    = a_neg ? (~a + 64'd1) : a;
    mag_b    = b_neg ? (~b + 64'd1) : b;
    shift_ok = (b[63:6] == 58'd0) && (b[5:0] != ShiftLimit);
    cross_lo = a[31:0] * b[63:32] + a[63:32] * b[31:0];

    entry_d         = '0;
    entry_d.valid   = in_valid_i;
    entry_d.command = in_i.command;
    entry_d.neg_q   = a_neg ^ b_neg;
    entry_d.neg_r   = a_neg;
    entry_d.prod_ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    entry_d.prod_x  = cross_lo;
    entry_d.den     = mag_b;
    entry_d.rem     = 64'd0;
    entry_d.quo     = mag_a;
    entry_d.ok      = in_i.operands_constant;
    case (cmd)
      CmdAdd: entry_d.misc = a + b;
      CmdSub: entry_d.misc = a - b;
      CmdMul: entry_d.misc = 64'd0;
      CmdDiv, CmdMod: begin
        entry_d.misc = 64'd0;
        entry_d.ok   = in_i.operands_constant && (b != 64'd0);
      end
      CmdAnd: entry_d.misc = a & b;
      CmdOr:  entry_d.misc = a | b;
      CmdXor: entry_d.misc = a ^ b;
      CmdShl: begin
        entry_d.misc = a << b[5:0];
        entry_d.ok   = in_i.operands_constant && shift_ok;
      end
      CmdShr: begin
        entry_d.misc = $signed(a) >>> b[5:0];
        entry_d.ok   = in_i.operands_constant && shift_ok;
      end
      CmdEq: entry_d.misc = {63'd0, a == b};
      CmdNe: entry_d.misc = {63'd0, a != b};
      CmdLt: entry_d.misc = {63'd0, $signed(a) <  $signed(b)};
      CmdLe: entry_d.misc = {63'd0, $signed(a) <= $signed(b)};
      CmdGt: entry_d.misc = {63'd0, $signed(a) >  $signed(b)};
      CmdGe: entry_d.misc = {63'd0, $signed(a) >= $signed(b)};
      default: begin
        entry_d.misc = 64'd0;
        entry_d.ok   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en) begin
      entry_q <= entry_d;
    end
  end

  // Divider chain: each cell produces one quotient bit, most significant
  // first, and carries every other result along unchanged.
  cfa_stage_t chain [0:DataW];
  assign chain[0] = entry_q;

  for (genvar i = 0; i < DataW; i++) begin : g_cell
    cfa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .stage_i(chain[i]),
      .stage_o(chain[i+1])
    );
  end

  // Final selection: sum the multiplier's partial products, apply the signs
  // of the quotient and remainder, and force the value to zero when the
  // transaction does not fold.
  cfa_stage_t last;
  cfa_out_t   out_d, out_q;
  logic       out_valid_q;
  logic [63:0] sel;

  always_comb begin
    last = chain[DataW];
    case (cfa_cmd_e'(last.command))
      CmdMul:  sel = last.prod_ll + {last.prod_x, 32'd0};
      CmdDiv:  sel = last.neg_q ? (~last.quo + 64'd1) : last.quo;
      CmdMod:  sel = last.neg_r ? (~last.rem + 64'd1) : last.rem;
      default: sel = last.misc;
    endcase
    out_d.folded = last.ok;
    out_d.value  = last.ok ? sel : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A transaction that does not fold always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.folded |-> out_o.value == 64'd0)
    else $error("unfolded result carries a non-zero value");

  // While the output is stalled, the last cell of the chain holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain[DataW]))
    else $error("divider chain moved while halted");

  // A folded compare yields only zero or one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid && last.ok && last.command >= CmdEq && last.command <= CmdGe
      |-> last.misc[63:1] == 63'd0)
    else $error("compare result wider than one bit");

endmodule
